### design/bbst_pkg.sv
`default_nettype none

package bbst_pkg;

   // Request mode codes
   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_FLIP   = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_STATUS = 2'd3;

   localparam int RSP_CNT_W = 11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT_WAIT,
      ST_FLIP_WAIT,
      ST_UP_WRITE,
      ST_UP_WAIT,
      ST_Q_CHECK,
      ST_Q_LWAIT,
      ST_Q_RCHECK,
      ST_Q_RWAIT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

### design/bracket_balance_segment_tree.sv
`default_nettype none

// Channel  Direction  Handshake              Beat payload
// req_     in         req_valid / req_ready  mode, position, bracket_value, range_low, range_high
// rsp_     out        rsp_valid / rsp_ready  unmatched_open, unmatched_close, balanced, range_error
//
// One request is worked at a time over the single node memory (one write and one
// registered read port). Write: each tree level stores the node and fetches its
// sibling, then combines the two, up to the root; flip first reads the leaf. Query: the
// left and right bounds each fetch at most one node per level. Status reads the root.
// After reset the memory is swept to zero, one node a cycle, over all 2*2^ceil(log2(LEAVES))
// nodes; req_ready stays low meanwhile. A finished result waits in the output register,
// so the next request is taken while rsp_ready is low.

module bracket_balance_segment_tree #(
   parameter int LEAVES = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [9:0]                     req_position,
   input  wire logic                           req_bracket_value,
   input  wire logic [9:0]                     req_range_low,
   input  wire logic [9:0]                     req_range_high,

   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bbst_pkg::RSP_CNT_W-1:0]      rsp_unmatched_open,
   output logic [bbst_pkg::RSP_CNT_W-1:0]      rsp_unmatched_close,
   output logic                                rsp_balanced,
   output logic                                rsp_range_error
);

   import bbst_pkg::*;

   localparam int LW    = $clog2(LEAVES);
   localparam int BASE  = 2 ** LW;          // first leaf node
   localparam int NW    = LW + 1;           // node address width
   localparam int DEPTH = 2 * BASE;
   localparam int CW    = $clog2(LEAVES + 1);

   typedef struct packed {
      logic [CW-1:0] n_open;
      logic [CW-1:0] n_close;
   } span_type;

   localparam span_type SPAN_EMPTY = '{n_open: '0, n_close: '0};
   localparam span_type SPAN_OPEN  = '{n_open: CW'(1), n_close: '0};
   localparam span_type SPAN_CLOSE = '{n_open: '0, n_close: CW'(1)};

   // Match the left span's opens against the right span's closes
   function automatic span_type combine(input span_type a, input span_type b);
      logic [CW-1:0] m;
      span_type      r;
      m         = (a.n_open < b.n_close) ? a.n_open : b.n_close;
      r.n_open  = a.n_open - m + b.n_open;
      r.n_close = b.n_close - m + a.n_close;
      return r;
   endfunction

   // Control registers
   state_type     state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [NW-1:0] k_ff, k_in;
   span_type      cur_ff, cur_in;
   logic [NW:0]   l_ff, l_in;
   logic [NW:0]   r_ff, r_in;
   span_type      la_ff, la_in;
   span_type      ra_ff, ra_in;
   span_type      res_ff, res_in;
   logic          err_ff, err_in;

   // Output payload
   logic [RSP_CNT_W-1:0] rsp_open_ff, rsp_open_in;
   logic [RSP_CNT_W-1:0] rsp_close_ff, rsp_close_in;
   logic                 rsp_bal_ff, rsp_bal_in;
   logic                 rsp_err_ff, rsp_err_in;

   // Memory port
   logic              wr_en;
   logic [NW-1:0]     wr_addr;
   span_type          wr_data;
   logic              rd_en;
   logic [NW-1:0]     rd_addr;
   logic [2*CW-1:0]   rd_raw;
   span_type          rd_span;

   logic              pos_ok;
   logic              range_ok;
   logic [NW-1:0]     leaf_addr;
   logic              out_free;

   bbst_ram #(
      .WIDTH (2 * CW),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_span = rd_raw;

   // Request decode; leaf address only matters when the position is in range
   assign pos_ok    = 32'(req_position) < 32'(LEAVES);
   assign range_ok  = (req_range_low <= req_range_high) &&
                      (32'(req_range_high) < 32'(LEAVES));
   assign leaf_addr = NW'(BASE) | NW'(req_position);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      la_in        = la_ff;
      ra_in        = ra_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_open_in  = rsp_open_ff;
      rsp_close_in = rsp_close_ff;
      rsp_bal_in   = rsp_bal_ff;
      rsp_err_in   = rsp_err_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = NW'(1);

      case (state_ff)
         ST_CLEAR: begin
            // sweep every node to empty
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = SPAN_EMPTY;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == NW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               err_in = 1'b0;
               k_in   = leaf_addr;
               la_in  = SPAN_EMPTY;
               ra_in  = SPAN_EMPTY;
               l_in   = (NW+1)'(BASE) + (NW+1)'(req_range_low);
               r_in   = (NW+1)'(BASE) + (NW+1)'(req_range_high) + (NW+1)'(1);
               case (req_mode)
                  MODE_WRITE: begin
                     if (pos_ok) begin
                        cur_in   = req_bracket_value ? SPAN_OPEN : SPAN_CLOSE;
                        state_in = ST_UP_WRITE;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_ROOT_WAIT;
                     end
                  end
                  MODE_FLIP: begin
                     rd_en = 1'b1;
                     if (pos_ok) begin
                        rd_addr  = leaf_addr;
                        state_in = ST_FLIP_WAIT;
                     end else begin
                        state_in = ST_ROOT_WAIT;
                     end
                  end
                  MODE_QUERY: begin
                     if (range_ok) begin
                        state_in = ST_Q_CHECK;
                     end else begin
                        err_in   = 1'b1;
                        res_in   = SPAN_EMPTY;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     // status: report the root
                     rd_en    = 1'b1;
                     state_in = ST_ROOT_WAIT;
                  end
               endcase
            end
         end

         ST_ROOT_WAIT: begin
            res_in   = rd_span;
            state_in = ST_EMIT;
         end

         ST_FLIP_WAIT: begin
            // an empty or closing leaf turns opening
            cur_in   = (rd_span.n_open == '0) ? SPAN_OPEN : SPAN_CLOSE;
            state_in = ST_UP_WRITE;
         end

         ST_UP_WRITE: begin
            // store this node, fetch its sibling
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = {k_ff[NW-1:1], ~k_ff[0]};
            if (k_ff == NW'(1)) begin
               res_in   = cur_ff;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_UP_WAIT;
            end
         end

         ST_UP_WAIT: begin
            cur_in   = k_ff[0] ? combine(rd_span, cur_ff) : combine(cur_ff, rd_span);
            k_in     = k_ff >> 1;
            state_in = ST_UP_WRITE;
         end

         ST_Q_CHECK: begin
            if (l_ff < r_ff) begin
               if (l_ff[0]) begin
                  rd_en    = 1'b1;
                  rd_addr  = l_ff[NW-1:0];
                  state_in = ST_Q_LWAIT;
               end else begin
                  state_in = ST_Q_RCHECK;
               end
            end else begin
               res_in   = combine(la_ff, ra_ff);
               state_in = ST_EMIT;
            end
         end

         ST_Q_LWAIT: begin
            la_in    = combine(la_ff, rd_span);
            l_in     = l_ff + (NW+1)'(1);
            state_in = ST_Q_RCHECK;
         end

         ST_Q_RCHECK: begin
            if (r_ff[0]) begin
               rd_en    = 1'b1;
               rd_addr  = NW'(r_ff - (NW+1)'(1));
               r_in     = r_ff - (NW+1)'(1);
               state_in = ST_Q_RWAIT;
            end else begin
               l_in     = l_ff >> 1;
               r_in     = r_ff >> 1;
               state_in = ST_Q_CHECK;
            end
         end

         ST_Q_RWAIT: begin
            ra_in    = combine(rd_span, ra_ff);
            l_in     = l_ff >> 1;
            r_in     = r_ff >> 1;
            state_in = ST_Q_CHECK;
         end

         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_open_in  = RSP_CNT_W'(res_ff.n_open);
               rsp_close_in = RSP_CNT_W'(res_ff.n_close);
               rsp_bal_in   = (res_ff == SPAN_EMPTY);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      la_ff        <= la_in;
      ra_ff        <= ra_in;
      res_ff       <= res_in;
      err_ff       <= err_in;
      rsp_open_ff  <= rsp_open_in;
      rsp_close_ff <= rsp_close_in;
      rsp_bal_ff   <= rsp_bal_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_unmatched_open  = rsp_open_ff;
   assign rsp_unmatched_close = rsp_close_ff;
   assign rsp_balanced        = rsp_bal_ff;
   assign rsp_range_error     = rsp_err_ff;

endmodule

`default_nettype wire

### design/bbst_ram.sv
`default_nettype none

module bbst_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
